@@ sv/bph_pkg.sv @@
// Shared types, constants and the dot-pattern function of the pattern halftoning block.
package bph_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_LIMIT  = 1024;
  localparam int WIDTH_RESET   = 512;
  localparam int HEIGHT_RESET  = 512;
  localparam int QUEUE_DEPTH   = 4;

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 2;
  localparam int BLK_W  = 9;
  localparam int PAT_W  = 9;
  localparam int SUM_W  = 12;
  localparam int SEG_W  = 10;
  localparam int ROW_W  = 10;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Classification of one pixel, passed from front to back
  typedef struct packed {
    logic             seg_start;  // first pixel of this block column in the current row
    logic             seg_end;    // last pixel of this block column in the current row
    logic             row_first;  // first row of the block: no earlier partial sum
    logic             emit;       // pixel completes the block
    logic             frame_end;  // final block of the image
    logic [BLK_W-1:0] block_row;
  } item_ctl_t;

  // Sum thresholds: mean >= T is the same as sum >= 9*T
  localparam logic [SUM_W-1:0] LEVEL_SUM [9] = '{
    12'd225, 12'd450, 12'd720, 12'd945, 12'd1170,
    12'd1440, 12'd1620, 12'd1890, 12'd2115
  };
  localparam logic [3:0] BIT_FOR [9] = '{
    4'd4, 4'd5, 4'd3, 4'd1, 4'd8, 4'd0, 4'd6, 4'd7, 4'd2
  };

  function automatic logic [PAT_W-1:0] make_pattern(input logic [SUM_W-1:0] total);
    logic [PAT_W-1:0] pat;
    pat = '0;
    for (int k = 0; k < 9; k++) begin
      if (total >= LEVEL_SUM[k]) pat[BIT_FOR[k]] = 1'b1;
    end
    return pat;
  endfunction

endpackage

@@ sv/bph_front.sv @@
// Front end: raster position counters, block classification and configuration registers.
module bph_front #(
  parameter int MAX_WIDTH = bph_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [bph_pkg::PIX_W-1:0]  in_pixel,
  input  logic                       cfg_valid,
  input  logic [bph_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bph_pkg::CFG_W-1:0]  cfg_data,
  output logic                       push,
  output logic [bph_pkg::PIX_W-1:0]  push_pixel,
  output logic [$clog2((MAX_WIDTH+2)/3 > 1 ? (MAX_WIDTH+2)/3 : 2)-1:0] push_bc,
  output bph_pkg::item_ctl_t         push_ctl
);

  localparam int SUM_SLOTS = (MAX_WIDTH + 2) / 3;
  localparam int BCW       = $clog2(SUM_SLOTS > 1 ? SUM_SLOTS : 2);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int W_RST     = (bph_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : bph_pkg::WIDTH_RESET;
  localparam int H_RST     = (bph_pkg::HEIGHT_RESET > bph_pkg::HEIGHT_LIMIT)
                             ? bph_pkg::HEIGHT_LIMIT : bph_pkg::HEIGHT_RESET;

  logic [CW-1:0]                 w_last_r, w_last_nxt;
  logic [bph_pkg::ROW_W-1:0]     h_last_r, h_last_nxt;
  logic [CW-1:0]                 col_count_r, col_count_nxt;
  logic [bph_pkg::ROW_W-1:0]     row_count_r, row_count_nxt;
  logic [1:0]                    col_phase_r, col_phase_nxt;
  logic [1:0]                    row_phase_r, row_phase_nxt;
  logic [BCW-1:0]                bc_r, bc_nxt;
  logic [bph_pkg::BLK_W-1:0]     brow_r, brow_nxt;
  logic                          last_col, last_row, cfg_hit;

  assign last_col = (col_count_r >= w_last_r);
  assign last_row = (row_count_r >= h_last_r);
  assign push     = in_valid && !in_stall;

  assign push_pixel          = in_pixel;
  assign push_bc             = bc_r;
  assign push_ctl.seg_start  = (col_phase_r == 2'd0);
  assign push_ctl.seg_end    = (col_phase_r == 2'd2) || last_col;
  assign push_ctl.row_first  = (row_phase_r == 2'd0);
  assign push_ctl.emit       = ((col_phase_r == 2'd2) || last_col) &&
                               ((row_phase_r == 2'd2) || last_row);
  assign push_ctl.frame_end  = last_col && last_row;
  assign push_ctl.block_row  = brow_r;

  assign cfg_hit = cfg_valid && ((cfg_index == bph_pkg::REG_IMAGE_WIDTH) ||
                                 (cfg_index == bph_pkg::REG_IMAGE_HEIGHT));

  always_comb begin
    w_last_nxt     = w_last_r;
    h_last_nxt     = h_last_r;
    col_count_nxt  = col_count_r;
    row_count_nxt  = row_count_r;
    col_phase_nxt  = col_phase_r;
    row_phase_nxt  = row_phase_r;
    bc_nxt         = bc_r;
    brow_nxt       = brow_r;
    if (cfg_hit) begin
      // clamp out-of-range sizes and restart the frame
      if (cfg_index == bph_pkg::REG_IMAGE_WIDTH) begin
        if (cfg_data == '0)                   w_last_nxt = '0;
        else if (int'(cfg_data) > MAX_WIDTH)  w_last_nxt = CW'(MAX_WIDTH - 1);
        else                                  w_last_nxt = CW'(cfg_data - 11'd1);
      end else begin
        if (cfg_data == '0)                   h_last_nxt = '0;
        else if (int'(cfg_data) > bph_pkg::HEIGHT_LIMIT)
          h_last_nxt = bph_pkg::ROW_W'(bph_pkg::HEIGHT_LIMIT - 1);
        else                                  h_last_nxt = bph_pkg::ROW_W'(cfg_data - 11'd1);
      end
      col_count_nxt = '0;
      row_count_nxt = '0;
      col_phase_nxt = '0;
      row_phase_nxt = '0;
      bc_nxt        = '0;
      brow_nxt      = '0;
    end else if (push) begin
      if (last_col) begin
        col_count_nxt = '0;
        col_phase_nxt = '0;
        bc_nxt        = '0;
        if (last_row) begin
          row_count_nxt = '0;
          row_phase_nxt = '0;
          brow_nxt      = '0;
        end else begin
          row_count_nxt = row_count_r + 1'b1;
          if (row_phase_r == 2'd2) begin
            row_phase_nxt = '0;
            brow_nxt      = brow_r + 1'b1;
          end else begin
            row_phase_nxt = row_phase_r + 1'b1;
          end
        end
      end else begin
        col_count_nxt = col_count_r + 1'b1;
        if (col_phase_r == 2'd2) begin
          col_phase_nxt = '0;
          bc_nxt        = bc_r + 1'b1;
        end else begin
          col_phase_nxt = col_phase_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r    <= CW'(W_RST - 1);
      h_last_r    <= bph_pkg::ROW_W'(H_RST - 1);
      col_count_r <= '0;
      row_count_r <= '0;
      col_phase_r <= '0;
      row_phase_r <= '0;
      bc_r        <= '0;
      brow_r      <= '0;
    end else begin
      w_last_r    <= w_last_nxt;
      h_last_r    <= h_last_nxt;
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      col_phase_r <= col_phase_nxt;
      row_phase_r <= row_phase_nxt;
      bc_r        <= bc_nxt;
      brow_r      <= brow_nxt;
    end
  end

endmodule

@@ sv/bph_queue.sv @@
// Short FIFO between the front end and the accumulation back end.
module bph_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bph_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == NW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ sv/bph_back.sv @@
// Back end: block sum memory, per-row accumulation, pattern lookup and output register.
module bph_back #(
  parameter int MAX_WIDTH = bph_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  logic [bph_pkg::PIX_W-1:0]  q_pixel,
  input  logic [$clog2((MAX_WIDTH+2)/3 > 1 ? (MAX_WIDTH+2)/3 : 2)-1:0] q_bc,
  input  bph_pkg::item_ctl_t         q_ctl,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bph_pkg::BLK_W-1:0]  out_block_row,
  output logic [bph_pkg::BLK_W-1:0]  out_block_col,
  output logic [bph_pkg::PAT_W-1:0]  out_pattern,
  output logic                       out_frame_end
);

  localparam int SUM_SLOTS = (MAX_WIDTH + 2) / 3;
  localparam int BCW       = $clog2(SUM_SLOTS > 1 ? SUM_SLOTS : 2);

  logic [bph_pkg::SUM_W-1:0] sums [SUM_SLOTS];

  logic                      adv;
  logic                      s1_valid_r;
  logic [bph_pkg::PIX_W-1:0] s1_pix_r;
  logic [BCW-1:0]            s1_bc_r;
  bph_pkg::item_ctl_t        s1_ctl_r;
  logic [bph_pkg::SUM_W-1:0] rdata_r;
  logic [bph_pkg::SEG_W-1:0] seg_acc_r;
  logic [bph_pkg::SEG_W-1:0] seg_val;
  logic [bph_pkg::SUM_W-1:0] base, total;
  logic                      we;

  logic                      s2_valid_r;
  logic [bph_pkg::SUM_W-1:0] s2_total_r;
  logic [bph_pkg::BLK_W-1:0] s2_brow_r;
  logic [bph_pkg::BLK_W-1:0] s2_bcol_r;
  logic                      s2_fend_r;

  logic                      out_valid_r;
  logic [bph_pkg::BLK_W-1:0] out_brow_r;
  logic [bph_pkg::BLK_W-1:0] out_bcol_r;
  logic [bph_pkg::PAT_W-1:0] out_pat_r;
  logic                      out_fend_r;

  // the whole back end holds while a result is stalled
  assign adv   = !(out_valid_r && out_stall);
  assign q_pop = adv && q_not_empty;

  assign seg_val = (s1_ctl_r.seg_start ? '0 : seg_acc_r) + bph_pkg::SEG_W'(s1_pix_r);
  assign base    = s1_ctl_r.row_first ? '0 : rdata_r;
  assign total   = base + bph_pkg::SUM_W'(seg_val);
  assign we      = adv && s1_valid_r && s1_ctl_r.seg_end;

  always_ff @(posedge clk) begin
    if (we) sums[s1_bc_r] <= total;
  end

  // registered read; forward a sum written in the same cycle
  always_ff @(posedge clk) begin
    if (adv) begin
      if (we && (s1_bc_r == q_bc)) rdata_r <= total;
      else                         rdata_r <= sums[q_bc];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_not_empty;
      s2_valid_r  <= s1_valid_r && s1_ctl_r.emit;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r <= q_pixel;
      s1_bc_r  <= q_bc;
      s1_ctl_r <= q_ctl;
      if (s1_valid_r) seg_acc_r <= seg_val;
      s2_total_r <= total;
      s2_brow_r  <= s1_ctl_r.block_row;
      s2_bcol_r  <= bph_pkg::BLK_W'(s1_bc_r);
      s2_fend_r  <= s1_ctl_r.frame_end;
      if (s2_valid_r) begin
        out_brow_r <= s2_brow_r;
        out_bcol_r <= s2_bcol_r;
        out_pat_r  <= bph_pkg::make_pattern(s2_total_r);
        out_fend_r <= s2_fend_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_block_row = out_brow_r;
  assign out_block_col = out_bcol_r;
  assign out_pattern   = out_pat_r;
  assign out_frame_end = out_fend_r;

endmodule

@@ sv/block_pattern_halftone.sv @@
// Top level of the 3x3 pattern halftoning block.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_pixel
//   out_    | output    | out_valid/out_stall| out_block_row, out_block_col, out_pattern,
//           |           |                    | out_frame_end
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One pixel per clock sustained while no result is stalled; a result passes the queue, sum
// memory read, accumulate and pattern register after the pixel that completes its block.
// The rate is set by the single read and single write port of the block sum memory, one
// read per pixel and one write per block row segment, with a same-address bypass.
// Synchronous active-low reset; the sum memory needs no clearing pass, as the first row
// of every block overwrites its entry.
// A stalled result freezes the back end; the four-entry queue keeps taking pixels until full.
module block_pattern_halftone #(
  parameter int MAX_WIDTH = bph_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bph_pkg::PIX_W-1:0]  in_pixel,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bph_pkg::BLK_W-1:0]  out_block_row,
  output logic [bph_pkg::BLK_W-1:0]  out_block_col,
  output logic [bph_pkg::PAT_W-1:0]  out_pattern,
  output logic                       out_frame_end,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bph_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bph_pkg::CFG_W-1:0]  cfg_data
);

  localparam int SUM_SLOTS = (MAX_WIDTH + 2) / 3;
  localparam int BCW       = $clog2(SUM_SLOTS > 1 ? SUM_SLOTS : 2);
  localparam int CTLW      = $bits(bph_pkg::item_ctl_t);
  localparam int QW        = bph_pkg::PIX_W + BCW + CTLW;

  logic                      push, q_full, q_not_empty, q_pop;
  logic [bph_pkg::PIX_W-1:0] push_pixel, q_pixel;
  logic [BCW-1:0]            push_bc, q_bc;
  bph_pkg::item_ctl_t        push_ctl, q_ctl;
  logic [QW-1:0]             q_head;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;

  bph_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (q_full),
    .in_pixel   (in_pixel),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_pixel (push_pixel),
    .push_bc    (push_bc),
    .push_ctl   (push_ctl)
  );

  bph_queue #(.WIDTH(QW), .DEPTH(bph_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_pixel, push_bc, push_ctl}),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_data (q_head)
  );

  assign q_pixel = q_head[QW-1 -: bph_pkg::PIX_W];
  assign q_bc    = q_head[CTLW +: BCW];
  assign q_ctl   = q_head[CTLW-1:0];

  bph_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_pixel       (q_pixel),
    .q_bc          (q_bc),
    .q_ctl         (q_ctl),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_block_row (out_block_row),
    .out_block_col (out_block_col),
    .out_pattern   (out_pattern),
    .out_frame_end (out_frame_end)
  );

endmodule

@@ sv/bph_checker.sv @@
// Port-level checker for the pattern halftoning block, with its bind.
module bph_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bph_pkg::BLK_W-1:0]  out_block_row,
  input logic [bph_pkg::BLK_W-1:0]  out_block_col,
  input logic [bph_pkg::PAT_W-1:0]  out_pattern,
  input logic                       out_frame_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pattern) &&
      $stable(out_block_row) && $stable(out_block_col) && $stable(out_frame_end))
    else $error("stalled result changed");

  // only the ten cumulative dot patterns can appear
  a_pattern_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pattern == 9'h000) || (out_pattern == 9'h010) ||
      (out_pattern == 9'h030) || (out_pattern == 9'h038) || (out_pattern == 9'h03A) ||
      (out_pattern == 9'h13A) || (out_pattern == 9'h13B) || (out_pattern == 9'h17B) ||
      (out_pattern == 9'h1FB) || (out_pattern == 9'h1FF))
    else $error("pattern is not a halftone level");

  // the queue only fills while the result side stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_stall) && $past(out_valid))
    else $error("input stalled without an output stall");

  // nothing comes out and the input is not stalled straight after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && !in_stall)
    else $error("activity straight after reset");

endmodule

bind block_pattern_halftone bph_checker u_bph_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_block_row (out_block_row),
  .out_block_col (out_block_col),
  .out_pattern   (out_pattern),
  .out_frame_end (out_frame_end)
);

@@ test/block_pattern_halftone_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the 3x3 pattern halftoning block: streams pixels, checks results.
module block_pattern_halftone_tb;

  localparam int SUM_SLOTS = (bph_pkg::MAX_WIDTH_DEF + 2) / 3;
  localparam int DIM_LIMIT = 1024;
  localparam int DRAIN     = 24;
  localparam int LIMIT     = 400000;
  localparam int RANDOM_PIXELS = 200;
  localparam int EDGE_RUN  = 60;

  // Indexes that decode to no register
  localparam logic [bph_pkg::IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [bph_pkg::IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int LEVELS [9] = '{25, 50, 80, 105, 130, 160, 180, 210, 235};

  typedef enum {TONE_ANY, TONE_EDGE, TONE_RAIL} tone_t;

  typedef struct {
    logic [bph_pkg::BLK_W-1:0] block_row;
    logic [bph_pkg::BLK_W-1:0] block_col;
    logic [bph_pkg::PAT_W-1:0] pattern;
    logic                      frame_end;
  } block_dots_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [bph_pkg::PIX_W-1:0] in_pixel  = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [bph_pkg::BLK_W-1:0] out_block_row;
  logic [bph_pkg::BLK_W-1:0] out_block_col;
  logic [bph_pkg::PAT_W-1:0] out_pattern;
  logic                      out_frame_end;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [bph_pkg::IDX_W-1:0] cfg_index = '0;
  logic [bph_pkg::CFG_W-1:0] cfg_data  = '0;

  block_pattern_halftone u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_block_row (out_block_row),
    .out_block_col (out_block_col),
    .out_pattern   (out_pattern),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state
  logic [bph_pkg::SUM_W-1:0] col_sums [SUM_SLOTS];
  int unsigned               pos_row, pos_col, phase_row, phase_col, blk_row, blk_col;
  logic [bph_pkg::CFG_W-1:0] reg_width, reg_height;

  logic [bph_pkg::PIX_W-1:0] pixel_q [$];
  block_dots_t      blocks_due [$];
  int               pixels_queued = 0;
  int               pixels_taken  = 0;
  int               err_count     = 0;
  int               in_gap        = 0;
  int               out_gap       = 0;
  bit               gaps_on       = 1'b1;

  function automatic int unsigned eff_dim(input logic [bph_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  function automatic void restart_position();
    pos_row = 0;
    pos_col = 0;
    phase_row = 0;
    phase_col = 0;
    blk_row = 0;
    blk_col = 0;
  endfunction

  function automatic void clear_predictor();
    foreach (col_sums[i]) col_sums[i] = '0;
    restart_position();
    reg_width  = bph_pkg::CFG_W'(bph_pkg::WIDTH_RESET);
    reg_height = bph_pkg::CFG_W'(bph_pkg::HEIGHT_RESET);
  endfunction

  function automatic void apply_reg(input logic [bph_pkg::IDX_W-1:0] idx,
                                    input logic [bph_pkg::CFG_W-1:0] val);
    if (idx == bph_pkg::REG_IMAGE_WIDTH) reg_width = val;
    else if (idx == bph_pkg::REG_IMAGE_HEIGHT) reg_height = val;
    else return;
    restart_position();
  endfunction

  // Bit 3r+c lights dot (r,c); each level adds one dot
  function automatic logic [bph_pkg::PAT_W-1:0] dot_pattern(
      input logic [bph_pkg::SUM_W-1:0] total);
    int unsigned mean;
    logic [bph_pkg::PAT_W-1:0] dots;
    mean = total / 9;
    dots = '0;
    if (mean >= 25)  dots[4] = 1'b1;  // centre
    if (mean >= 50)  dots[5] = 1'b1;
    if (mean >= 80)  dots[3] = 1'b1;
    if (mean >= 105) dots[1] = 1'b1;
    if (mean >= 130) dots[8] = 1'b1;
    if (mean >= 160) dots[0] = 1'b1;
    if (mean >= 180) dots[6] = 1'b1;
    if (mean >= 210) dots[7] = 1'b1;
    if (mean >= 235) dots[2] = 1'b1;
    return dots;
  endfunction

  function automatic void tally_pixel(input logic [bph_pkg::PIX_W-1:0] p);
    int unsigned w, h, bc;
    logic last_c, last_r;
    block_dots_t r;
    w = eff_dim(reg_width);
    h = eff_dim(reg_height);
    bc = (blk_col >= SUM_SLOTS) ? SUM_SLOTS - 1 : blk_col;
    last_c = (pos_col >= w - 1);
    last_r = (pos_row >= h - 1);
    // First pixel of a block overwrites the running sum
    if (phase_row == 0 && phase_col == 0) col_sums[bc] = bph_pkg::SUM_W'(p);
    else col_sums[bc] = col_sums[bc] + bph_pkg::SUM_W'(p);
    if ((phase_col == 2 || last_c) && (phase_row == 2 || last_r)) begin
      r.block_row = bph_pkg::BLK_W'(blk_row);
      r.block_col = bph_pkg::BLK_W'(bc);
      r.pattern   = dot_pattern(col_sums[bc]);
      r.frame_end = last_c && last_r;
      blocks_due.push_back(r);
    end
    if (last_c) begin
      pos_col = 0;
      phase_col = 0;
      blk_col = 0;
      if (last_r) begin
        pos_row = 0;
        phase_row = 0;
        blk_row = 0;
      end else begin
        pos_row++;
        if (phase_row >= 2) begin
          phase_row = 0;
          blk_row++;
        end else begin
          phase_row++;
        end
      end
    end else begin
      pos_col++;
      if (phase_col >= 2) begin
        phase_col = 0;
        blk_col++;
      end else begin
        phase_col++;
      end
    end
  endfunction

  task automatic report(input string what, input int got, input int want);
    err_count++;
    // limit log size, keep counting
    if (err_count <= 200)
      $display("mismatch on %s after pixel %0d: got %0d, want %0d", what, pixels_taken, got, want);
  endtask

  // Pixel sender
  always @(posedge clk) begin : drive_pixels
    logic busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_pixel <= '0;
      in_gap = 0;
      clear_predictor();
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        tally_pixel(in_pixel);
        pixels_taken++;
        busy = 1'b0;
      end
      // hold a stalled transaction, otherwise idle or advance
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          in_pixel <= pixel_q.pop_front();
          in_valid <= 1'b1;
          in_gap = gaps_on ? $urandom_range(0, 6) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver and checker
  always @(posedge clk) begin : watch_results
    block_dots_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (blocks_due.size() == 0) begin
          report("block_col of unexpected result", int'(out_block_col), -1);
        end else begin
          due = blocks_due.pop_front();
          if (out_block_row !== due.block_row)
            report("block_row", int'(out_block_row), int'(due.block_row));
          if (out_block_col !== due.block_col)
            report("block_col", int'(out_block_col), int'(due.block_col));
          if (out_pattern !== due.pattern)
            report("pattern", int'(out_pattern), int'(due.pattern));
          if (out_frame_end !== due.frame_end)
            report("frame_end", int'(out_frame_end), int'(due.frame_end));
        end
        out_gap = gaps_on ? $urandom_range(0, 6) : 0;
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [bph_pkg::PIX_W-1:0] draw_pixel(input tone_t tone);
    int lvl;
    case (tone)
      TONE_EDGE: begin
        // cluster around a threshold so block means land on either side of it
        lvl = LEVELS[$urandom_range(0, 8)];
        lvl = lvl + int'($urandom_range(0, 4)) - 2;
        return bph_pkg::PIX_W'(lvl);
      end
      TONE_RAIL: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:   return bph_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [bph_pkg::CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return bph_pkg::CFG_W'($urandom_range(DIM_LIMIT + 1, 2047));
      2, 3:    return bph_pkg::CFG_W'($urandom_range(13, 40));
      default: return bph_pkg::CFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic write_reg(input logic [bph_pkg::IDX_W-1:0] idx,
                           input logic [bph_pkg::CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_pixel(input logic [bph_pkg::PIX_W-1:0] p);
    pixel_q.push_back(p);
    pixels_queued++;
  endtask

  // Wait until every pixel has gone in and every block result has come out
  task automatic settle();
    while (pixels_taken != pixels_queued || blocks_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic feed(input int n, input tone_t tone);
    for (int i = 0; i < n; i++) queue_pixel(draw_pixel(tone));
    settle();
  endtask

  initial begin : stimulus
    int n, frame, rand_pixels;
    logic [bph_pkg::CFG_W-1:0] w, h;
    tone_t tone;
    rand_pixels = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero sizes act as a one-pixel image: every pixel is a whole frame
    write_reg(bph_pkg::REG_IMAGE_WIDTH, '0);
    write_reg(bph_pkg::REG_IMAGE_HEIGHT, '0);
    queue_pixel(8'd0);
    queue_pixel(8'd255);
    queue_pixel(8'd225);
    queue_pixel(8'd224);
    settle();

    // One full block at white
    write_reg(bph_pkg::REG_IMAGE_WIDTH, 11'd3);
    write_reg(bph_pkg::REG_IMAGE_HEIGHT, 11'd3);
    for (int i = 0; i < 9; i++) queue_pixel(8'd255);
    settle();

    // Narrow edge block with zero padding; spare indexes written mid-frame must not restart
    write_reg(bph_pkg::REG_IMAGE_WIDTH, 11'd4);
    write_reg(bph_pkg::REG_IMAGE_HEIGHT, 11'd2);
    queue_pixel(8'd200);
    queue_pixel(8'd13);
    queue_pixel(8'd97);
    queue_pixel(8'd255);
    settle();
    write_reg(REG_SPARE_3, 11'h7FF);
    write_reg(REG_SPARE_2, 11'h000);
    queue_pixel(8'd0);
    queue_pixel(8'd128);
    queue_pixel(8'd60);
    queue_pixel(8'd255);
    settle();

    // Over-range width clamps; with a single row every third pixel completes a block
    write_reg(bph_pkg::REG_IMAGE_WIDTH, 11'h7FF);
    write_reg(bph_pkg::REG_IMAGE_HEIGHT, 11'd1);
    feed(EDGE_RUN, TONE_ANY);

    // One-pixel column at the height limit
    write_reg(bph_pkg::REG_IMAGE_WIDTH, 11'd1);
    write_reg(bph_pkg::REG_IMAGE_HEIGHT, 11'(DIM_LIMIT));
    feed(EDGE_RUN, TONE_EDGE);

    // Largest image, first row only: nothing may come out
    write_reg(bph_pkg::REG_IMAGE_WIDTH, 11'(DIM_LIMIT));
    write_reg(bph_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
    feed(30, TONE_RAIL);

    while (rand_pixels < RANDOM_PIXELS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      w = pick_dim();
      h = pick_dim();
      if ($urandom_range(0, 4) == 0)
        write_reg(REG_SPARE_2 | bph_pkg::IDX_W'($urandom_range(0, 1)),
                  bph_pkg::CFG_W'($urandom_range(0, 2047)));
      case ($urandom_range(0, 3))
        0: write_reg(bph_pkg::REG_IMAGE_WIDTH, w);
        1: write_reg(bph_pkg::REG_IMAGE_HEIGHT, h);
        default: begin
          write_reg(bph_pkg::REG_IMAGE_WIDTH, w);
          write_reg(bph_pkg::REG_IMAGE_HEIGHT, h);
        end
      endcase
      frame = eff_dim(reg_width) * eff_dim(reg_height);
      if (frame <= 60) n = frame * $urandom_range(1, 2) + $urandom_range(0, frame);
      else n = $urandom_range(20, 120);
      tone = tone_t'($urandom_range(0, 2));
      feed(n, tone);
      rand_pixels += n;
    end

    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
